### sv/bdq_pkg.sv
package bdq_pkg;

  localparam int DEPTH = 16;
  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int DATA_W = 32;
  localparam int LIM_W = 5;
  localparam int ADDR_W = 3;

  localparam logic [LIM_W-1:0] LIMIT_RESET = LIM_W'(10);

  localparam logic [1:0] CMD_PUSH_BACK = 2'd0;
  localparam logic [1:0] CMD_PUSH_FRONT = 2'd1;
  localparam logic [1:0] CMD_POP_FRONT = 2'd2;
  localparam logic [1:0] CMD_SEARCH = 2'd3;

  localparam logic [1:0] ST_DONE = 2'd0;
  localparam logic [1:0] ST_FULL = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  localparam logic REG_CAPACITY = 1'b0;

  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [CNT_W-1:0] cnt_t;

  typedef struct packed {
    logic en;
    idx_t addr;
    logic signed [DATA_W-1:0] data;
  } mem_wr_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] value;
    logic hit;
    idx_t position;
    logic [1:0] status;
  } result_t;

  function automatic idx_t wrap_add(idx_t base, cnt_t off);
    logic [CNT_W:0] sum;
    sum = {{(CNT_W + 1 - IDX_W){1'b0}}, base} + {1'b0, off};
    if (sum >= (CNT_W + 1)'(DEPTH)) begin
      sum = sum - (CNT_W + 1)'(DEPTH);
    end
    return sum[IDX_W-1:0];
  endfunction

endpackage

### sv/bounded_deque_with_search.sv
// Bounded double-ended queue of signed 32-bit words with a linear search.
// Commands arrive on the input channel (in_valid, in_stall, command,
// item_value) and every command yields exactly one result word on the
// output channel (out_valid, out_stall, out_value, hit, hit_position,
// status, occupancy). A word moves when valid is high and stall is low.
// The block works on one command at a time. A push, a refused push and a
// pop on an empty queue go from acceptance straight to the finish state;
// a pop that returns a word passes the pop state first. A search reads one
// stored entry per cycle from the single read port of the entry memory
// and stops at the first match or the last stored entry. The next command
// is taken once its predecessor has left the finish state.
// The result sits in an output register, so the next command is taken
// while a result still waits; a stalled output holds its word, and a
// second result waits inside the block until the register frees up.
// The user writes the capacity limit over APB at address 0 only while the
// block is idle; the block does not enforce it. Values above 16 act as 16.
// Reset empties the queue, sets the limit to 10 and clears no stored word.
module bounded_deque_with_search import bdq_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [1:0]               command,
  input  logic signed [DATA_W-1:0] item_value,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic signed [DATA_W-1:0] out_value,
  output logic                     hit,
  output logic [IDX_W-1:0]         hit_position,
  output logic [1:0]               status,
  output logic [CNT_W-1:0]         occupancy,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [ADDR_W-1:0]        paddr,
  input  logic [31:0]              pwdata,
  output logic [31:0]              prdata,
  output logic                     pready
);

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_POP    = 4'b0010,
    S_SEARCH = 4'b0100,
    S_FIN    = 4'b1000
  } state_t;

  state_t state, state_next;
  idx_t head, head_next;
  cnt_t count, count_next;
  logic [LIM_W-1:0] limit;
  idx_t scan_pos, scan_pos_next;
  logic signed [DATA_W-1:0] key;
  result_t res, res_next;

  mem_wr_t wr;
  idx_t raddr;
  logic signed [DATA_W-1:0] rdata;

  logic accept;
  logic full;
  cnt_t eff_limit;
  logic out_free;

  bdq_store u_store (
    .clk   (clk),
    .wr    (wr),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_CAPACITY) ? {{(32 - LIM_W){1'b0}}, limit} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      limit <= LIMIT_RESET;
    end else if (psel && penable && pwrite && paddr[2] == REG_CAPACITY) begin
      limit <= pwdata[LIM_W-1:0];
    end
  end

  assign in_stall = (state != S_IDLE);
  assign accept = in_valid && !in_stall;
  assign eff_limit = ({{(CNT_W > LIM_W ? CNT_W - LIM_W : 0){1'b0}}, limit} > CNT_W'(DEPTH))
                     ? CNT_W'(DEPTH) : CNT_W'(limit);
  assign full = (count >= eff_limit);
  assign out_free = !out_valid || !out_stall;

  always_comb begin
    raddr = head;
    if (state == S_SEARCH) begin
      raddr = wrap_add(head, CNT_W'(scan_pos) + CNT_W'(1));
    end
  end

  always_comb begin
    state_next = state;
    head_next = head;
    count_next = count;
    scan_pos_next = scan_pos;
    res_next = res;
    wr = '0;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          res_next = '0;
          res_next.status = ST_DONE;
          scan_pos_next = '0;
          state_next = S_FIN;
          unique case (command)
            CMD_PUSH_BACK: begin
              if (full) begin
                res_next.status = ST_FULL;
              end else begin
                wr.en = 1'b1;
                wr.addr = wrap_add(head, count);
                wr.data = item_value;
                count_next = count + CNT_W'(1);
              end
            end
            CMD_PUSH_FRONT: begin
              if (full) begin
                res_next.status = ST_FULL;
              end else begin
                head_next = (head == '0) ? IDX_W'(DEPTH - 1) : head - IDX_W'(1);
                wr.en = 1'b1;
                wr.addr = head_next;
                wr.data = item_value;
                count_next = count + CNT_W'(1);
              end
            end
            CMD_POP_FRONT: begin
              if (count == '0) begin
                res_next.status = ST_EMPTY;
              end else begin
                state_next = S_POP;
              end
            end
            CMD_SEARCH: begin
              if (count != '0) begin
                state_next = S_SEARCH;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_POP: begin
        res_next.value = rdata;
        head_next = wrap_add(head, CNT_W'(1));
        count_next = count - CNT_W'(1);
        state_next = S_FIN;
      end
      S_SEARCH: begin
        if (rdata == key) begin
          res_next.hit = 1'b1;
          res_next.position = scan_pos;
          state_next = S_FIN;
        end else if (CNT_W'(scan_pos) == count - CNT_W'(1)) begin
          state_next = S_FIN;
        end else begin
          scan_pos_next = scan_pos + IDX_W'(1);
        end
      end
      S_FIN: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      head <= '0;
      count <= '0;
    end else begin
      state <= state_next;
      head <= head_next;
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    scan_pos <= scan_pos_next;
    res <= res_next;
    if (accept) begin
      key <= item_value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_FIN && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_FIN && out_free) begin
      out_value <= res.value;
      hit <= res.hit;
      hit_position <= res.position;
      status <= res.status;
      occupancy <= count;
    end
  end

  assert property (@(posedge clk) disable iff (rst) count <= CNT_W'(DEPTH))
    else $error("entry count exceeds the queue depth");

  assert property (@(posedge clk) disable iff (rst)
    accept && !full && (command == CMD_PUSH_BACK || command == CMD_PUSH_FRONT)
    |=> count == $past(count) + CNT_W'(1))
    else $error("accepted push did not grow the queue");

  assert property (@(posedge clk) disable iff (rst)
    out_valid && hit |-> status == ST_DONE && occupancy != '0)
    else $error("search hit reported with bad status or empty queue");

  assert property (@(posedge clk) disable iff (rst)
    state == S_SEARCH |-> count != '0 && CNT_W'(scan_pos) < count)
    else $error("search scans beyond the stored entries");

endmodule

### sv/bdq_store.sv
module bdq_store import bdq_pkg::*; (
  input  logic                     clk,
  input  mem_wr_t                  wr,
  input  idx_t                     raddr,
  output logic signed [DATA_W-1:0] rdata
);

  logic signed [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

### tb/sv/bounded_deque_with_search_tb.sv
`timescale 1ns / 100ps

import bdq_pkg::*;

typedef struct {
  logic signed [DATA_W-1:0] value;
  logic                     hit;
  logic [IDX_W-1:0]         position;
  logic [1:0]               status;
  logic [CNT_W-1:0]         occupancy;
} deque_result_t;

class deque_scoreboard;
  logic signed [DATA_W-1:0] entries[DEPTH];
  int unsigned head;
  int unsigned count;
  logic [LIM_W-1:0] limit;
  deque_result_t pending_results[$];
  int mismatch_count;

  function new();
    head = 0;
    count = 0;
    limit = LIMIT_RESET;
    mismatch_count = 0;
    foreach (entries[i]) entries[i] = '0;
  endfunction

  function void set_limit(logic [LIM_W-1:0] value);
    limit = value;
  endfunction

  function int unsigned room_limit();
    return (limit > DEPTH) ? DEPTH : limit;
  endfunction

  function logic signed [DATA_W-1:0] entry_at(int unsigned pos);
    return entries[(head + pos) % DEPTH];
  endfunction

  function void report_mismatch(string what, logic [DATA_W-1:0] got, logic [DATA_W-1:0] want);
    $display("mismatch: %s got %0h expected %0h", what, got, want);
    mismatch_count++;
  endfunction

  function void note_command(logic [1:0] cmd, logic signed [DATA_W-1:0] val);
    deque_result_t r;
    r.value = '0;
    r.hit = 1'b0;
    r.position = '0;
    r.status = ST_DONE;
    case (cmd)
      CMD_PUSH_BACK: begin
        if (count >= room_limit()) begin
          r.status = ST_FULL;
        end else begin
          entries[(head + count) % DEPTH] = val;
          count++;
        end
      end
      CMD_PUSH_FRONT: begin
        if (count >= room_limit()) begin
          r.status = ST_FULL;
        end else begin
          head = (head + DEPTH - 1) % DEPTH;
          entries[head] = val;
          count++;
        end
      end
      CMD_POP_FRONT: begin
        if (count == 0) begin
          r.status = ST_EMPTY;
        end else begin
          r.value = entries[head];
          head = (head + 1) % DEPTH;
          count--;
        end
      end
      default: begin
        for (int i = 0; i < count; i++) begin
          if (!r.hit && entry_at(i) == val) begin
            r.hit = 1'b1;
            r.position = IDX_W'(i);
          end
        end
      end
    endcase
    r.occupancy = CNT_W'(count);
    pending_results.push_back(r);
  endfunction

  function void check_result(logic signed [DATA_W-1:0] value, logic hit, logic [IDX_W-1:0] position,
                             logic [1:0] status, logic [CNT_W-1:0] occupancy);
    deque_result_t r;
    if (pending_results.size() == 0) begin
      report_mismatch("result word with nothing pending, value", value, '0);
      return;
    end
    r = pending_results.pop_front();
    if (value !== r.value) report_mismatch("out_value", value, r.value);
    if (hit !== r.hit) report_mismatch("hit", hit, r.hit);
    if (position !== r.position) report_mismatch("hit_position", position, r.position);
    if (status !== r.status) report_mismatch("status", status, r.status);
    if (occupancy !== r.occupancy) report_mismatch("occupancy", occupancy, r.occupancy);
  endfunction
endclass

module bounded_deque_with_search_tb;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int MAX_GAP = 18;
  localparam int SETTLE_CYCLES = 24;
  localparam int DRAIN_CYCLES = 40;
  localparam int PHASES = 10;
  localparam int PHASE_ITEMS = 123;

  logic                     clk;
  logic                     rst;
  logic                     in_valid;
  logic                     in_stall;
  logic [1:0]               command;
  logic signed [DATA_W-1:0] item_value;
  logic                     out_valid;
  logic                     out_stall;
  logic signed [DATA_W-1:0] out_value;
  logic                     hit;
  logic [IDX_W-1:0]         hit_position;
  logic [1:0]               status;
  logic [CNT_W-1:0]         occupancy;
  logic                     psel;
  logic                     penable;
  logic                     pwrite;
  logic [ADDR_W-1:0]        paddr;
  logic [31:0]              pwdata;
  logic [31:0]              prdata;
  logic                     pready;

  deque_scoreboard sb = new();
  int idle_cycles;
  bit steady;

  bounded_deque_with_search dut (.*);

  always #5 clk = ~clk;

  function automatic int draw_gap();
    if (steady) return 0;
    if ($urandom_range(0, 2) == 0) return $urandom_range(0, MAX_GAP);
    return $urandom_range(0, 2);
  endfunction

  function automatic logic signed [DATA_W-1:0] pick_value();
    case ($urandom_range(0, 5))
      0: begin
        case ($urandom_range(0, 3))
          0: return 32'sh7FFF_FFFF;
          1: return 32'sh8000_0000;
          2: return 32'sh0;
          default: return -32'sd1;
        endcase
      end
      1, 2: return $signed(DATA_W'($urandom_range(0, 7))) - 32'sd4;
      default: return $signed(DATA_W'($urandom));
    endcase
  endfunction

  function automatic logic signed [DATA_W-1:0] pick_search_value();
    if (sb.count > 0 && $urandom_range(0, 2) != 0) return sb.entry_at($urandom_range(0, sb.count - 1));
    return pick_value();
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      idle_cycles <= 0;
    end else begin
      if (in_valid && !in_stall) sb.note_command(command, item_value);
      if (out_valid && !out_stall) begin
        sb.check_result(out_value, hit, hit_position, status, occupancy);
      end
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || psel) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("bounded_deque_with_search_tb: done, errors");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    int n;
    forever begin
      n = draw_gap();
      repeat (n) begin
        out_stall <= 1'b1;
        @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!(out_valid && !out_stall));
    end
  end

  task automatic send_command(input logic [1:0] cmd, input logic signed [DATA_W-1:0] val);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    command <= cmd;
    item_value <= val;
    do @(posedge clk); while (!(in_valid && !in_stall));
  endtask

  task automatic set_capacity(input logic [LIM_W-1:0] lim);
    logic [ADDR_W-1:0] addr;
    logic [31:0] readback;
    addr = ADDR_W'(4 * REG_CAPACITY);
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= {27'($urandom), lim};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    sb.set_limit(lim);
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    psel <= 1'b1;
    pwrite <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    readback = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
    if (readback[LIM_W-1:0] !== lim) sb.report_mismatch("capacity readback", readback, 32'(lim));
    @(posedge clk);
  endtask

  initial begin
    int bias;
    int unsigned r;
    logic [1:0] cmd;
    logic signed [DATA_W-1:0] val;
    logic [LIM_W-1:0] lim;
    clk = 1'b0;
    rst = 1'b1;
    in_valid = 1'b0;
    command = CMD_PUSH_BACK;
    item_value = '0;
    out_stall = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    steady = 1'b0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_command(CMD_POP_FRONT, pick_value());
    send_command(CMD_SEARCH, 32'sh0);
    send_command(CMD_PUSH_BACK, 32'sh7FFF_FFFF);
    send_command(CMD_PUSH_FRONT, 32'sh8000_0000);
    send_command(CMD_PUSH_FRONT, -32'sd1);
    send_command(CMD_PUSH_BACK, 32'sh0);
    send_command(CMD_SEARCH, -32'sd1);
    send_command(CMD_SEARCH, 32'sh0);
    send_command(CMD_SEARCH, 32'sh7FFF_FFFF);
    send_command(CMD_SEARCH, 32'sd12345);
    send_command(CMD_POP_FRONT, 32'sh7FFF_FFFF);
    repeat (7) send_command(CMD_PUSH_BACK, $signed(DATA_W'($urandom)));
    send_command(CMD_PUSH_BACK, 32'sd77);
    send_command(CMD_PUSH_FRONT, 32'sd78);
    send_command(CMD_SEARCH, 32'sh8000_0000);
    set_capacity(LIM_W'(3));
    send_command(CMD_PUSH_BACK, 32'sd5);
    send_command(CMD_POP_FRONT, 32'sd0);
    send_command(CMD_SEARCH, 32'sh7FFF_FFFF);

    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: lim = LIM_W'(16);
        1: lim = LIM_W'(1);
        2: lim = LIM_W'(31);
        3: lim = LIM_W'(0);
        4: lim = LIM_W'(17);
        default: lim = LIM_W'($urandom_range(0, 31));
      endcase
      set_capacity(lim);
      bias = 50;
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        if (k % 30 == 0) begin
          case ($urandom_range(0, 2))
            0: bias = 20;
            1: bias = 50;
            default: bias = 80;
          endcase
          steady = ($urandom_range(0, 3) == 0);
        end
        r = $urandom_range(0, 99);
        if (r < bias) begin
          cmd = $urandom_range(0, 1) ? CMD_PUSH_FRONT : CMD_PUSH_BACK;
          val = pick_value();
        end else if ($urandom_range(0, 9) < 6) begin
          cmd = CMD_POP_FRONT;
          val = $signed(DATA_W'($urandom));
        end else begin
          cmd = CMD_SEARCH;
          val = pick_search_value();
        end
        send_command(cmd, val);
      end
    end
    steady = 1'b0;

    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.mismatch_count == 0) begin
      $display("bounded_deque_with_search_tb: done, clean");
    end else begin
      $display("bounded_deque_with_search_tb: done, errors");
    end
    $finish;
  end
endmodule

### sim.f
sv/bdq_pkg.sv
sv/bdq_store.sv
sv/bounded_deque_with_search.sv
tb/sv/bounded_deque_with_search_tb.sv
